// ===== rtl/assert_macros.svh =====
// assertion macros for the overlap test checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every edge outside reset
`define CHK_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked at every edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== rtl/atov_pkg.sv =====
// shared constants and types for the box-triangle overlap test
package atov_pkg;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned PaddrW = 5;
  typedef enum logic [2:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } reg_idx_e;
endpackage

// ===== rtl/atov_if.sv =====
// valid/ready channel interfaces for triangle items and result items
interface atov_tri_if #(parameter int CoordBits = 16);
  logic valid;
  logic ready;
  logic signed [CoordBits-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface atov_res_if;
  logic valid;
  logic ready;
  logic overlaps;
  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

// ===== rtl/atov_axis.sv =====
// one cross-product axis test: projection stages and interval compare
module atov_axis
  import atov_pkg::*;
#(
  parameter int CoordBits = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [CoordBits:0] ax0_i,
  input  logic signed [CoordBits:0] ax1_i,
  input  logic signed [CoordBits:0] pa0_i, pa1_i,
  input  logic signed [CoordBits:0] pb0_i, pb1_i,
  input  logic signed [CoordBits:0] pc0_i, pc1_i,
  input  logic signed [CoordBits:0] lo0_i, lo1_i,
  input  logic signed [CoordBits:0] hi0_i, hi1_i,
  output logic                      sep_o
);
  localparam int PW = 2 * CoordBits + 2;
  localparam int SW = PW + 1;
  // stage 1: products
  logic signed [PW-1:0] pa0_q, pa1_q, pb0_q, pb1_q, pc0_q, pc1_q;
  logic signed [PW-1:0] l0_q, h0_q, l1_q, h1_q;
  logic                 nz_q;
  // stage 2: sums and interval ends
  logic signed [SW-1:0] ta_q, tb_q, tc_q, bmin_q, bmax_q;
  logic                 nz2_q;
  logic signed [SW-1:0] tmin, tmax;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa0_q <= PW'(ax0_i * pa0_i);
      pa1_q <= PW'(ax1_i * pa1_i);
      pb0_q <= PW'(ax0_i * pb0_i);
      pb1_q <= PW'(ax1_i * pb1_i);
      pc0_q <= PW'(ax0_i * pc0_i);
      pc1_q <= PW'(ax1_i * pc1_i);
      l0_q  <= PW'(ax0_i * lo0_i);
      h0_q  <= PW'(ax0_i * hi0_i);
      l1_q  <= PW'(ax1_i * lo1_i);
      h1_q  <= PW'(ax1_i * hi1_i);
      nz_q  <= (ax0_i != '0) || (ax1_i != '0);
      ta_q  <= SW'(pa0_q) + SW'(pa1_q);
      tb_q  <= SW'(pb0_q) + SW'(pb1_q);
      tc_q  <= SW'(pc0_q) + SW'(pc1_q);
      bmin_q <= ((l0_q < h0_q) ? SW'(l0_q) : SW'(h0_q))
              + ((l1_q < h1_q) ? SW'(l1_q) : SW'(h1_q));
      bmax_q <= ((l0_q < h0_q) ? SW'(h0_q) : SW'(l0_q))
              + ((l1_q < h1_q) ? SW'(h1_q) : SW'(l1_q));
      nz2_q <= nz_q;
    end
  end

  always_comb begin
    tmin = ta_q;
    tmax = ta_q;
    if (tb_q < tmin) tmin = tb_q;
    if (tc_q < tmin) tmin = tc_q;
    if (tb_q > tmax) tmax = tb_q;
    if (tc_q > tmax) tmax = tc_q;
  end

  assign sep_o = nz2_q && ((bmax_q < tmin) || (tmax < bmin_q));
endmodule

// ===== rtl/aabb_triangle_overlap.sv =====
// an accepted item passes the stage 0 registers, the product and sum stages of the axis units, then the output register
// throughput: one item per cycle while the output is not stalled; the nine axis units are fully pipelined
// a stall freezes all stages together, the output register holds the result
// reset clears the box registers to zero and all valid bits
// products of the axis units set the stage depth
module aabb_triangle_overlap
  import atov_pkg::*;
#(
  parameter int CoordBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  atov_tri_if.sink           tri_i,
  atov_res_if.source         res_o
);
  localparam int CW = CoordBits + 1;
  logic signed [CoordBits-1:0] box_q [NumRegs];
  reg_idx_e widx;
  logic [2:0] v_q;
  logic out_v_q, out_q;
  logic adv;
  // stage 0 registers
  logic signed [CW-1:0] e_q [3][3];
  logic signed [CW-1:0] p_q [3][3];
  logic signed [CW-1:0] lo_q [3], hi_q [3];
  logic ext_sep_q, ext_sep1_q, ext_sep2_q;
  logic ext_sep;
  logic [8:0] sep;
  logic signed [CoordBits-1:0] v [3][3];

  assign pready = 1'b1;
  assign widx = reg_idx_e'(paddr[PaddrW-1:2]);
  assign adv = !v_q[2] || !out_v_q || res_o.ready;
  assign tri_i.ready = adv;

  always_comb begin
    prdata = '0;
    if (paddr[PaddrW-1:2] < 3'(NumRegs))
      prdata = 32'(box_q[paddr[PaddrW-1:2]]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) box_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        RegMinX, RegMinY, RegMinZ, RegMaxX, RegMaxY, RegMaxZ:
          box_q[widx] <= pwdata[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  assign v[0] = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign v[1] = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign v[2] = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[1:0], tri_i.valid};
        if (v_q[2]) out_v_q <= 1'b1;
        else if (res_o.ready) out_v_q <= 1'b0;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // triangle extent against the box on each coordinate
  always_comb begin
    ext_sep = 1'b0;
    for (int k = 0; k < 3; k++) begin
      logic signed [CoordBits-1:0] mn2, mx2;
      mn2 = v[0][k];
      mx2 = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < mn2) mn2 = v[i][k];
        if (v[i][k] > mx2) mx2 = v[i][k];
      end
      if (mx2 < box_q[k] || mn2 > box_q[k+3]) ext_sep = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= CW'(box_q[k]);
        hi_q[k] <= CW'(box_q[k+3]);
        for (int i = 0; i < 3; i++) p_q[i][k] <= CW'(v[i][k]);
        e_q[0][k] <= CW'(v[0][k]) - CW'(v[1][k]);
        e_q[1][k] <= CW'(v[1][k]) - CW'(v[2][k]);
        e_q[2][k] <= CW'(v[2][k]) - CW'(v[0][k]);
      end
      ext_sep_q <= ext_sep;
      ext_sep1_q <= ext_sep_q;
      ext_sep2_q <= ext_sep1_q;
      if (v_q[2]) out_q <= !(ext_sep2_q || (sep != '0));
    end
  end

  // axis for edge i and box axis j uses the two other coordinates (u, w)
  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar j = 0; j < 3; j++) begin : g_ax
      localparam int U = (j + 1) % 3;
      localparam int W = (j + 2) % 3;
      atov_axis #(.CoordBits(CoordBits)) u_axis (
        .clk_i (clk_i),
        .en_i  (adv),
        .ax0_i (e_q[i][W]),
        .ax1_i (-e_q[i][U]),
        .pa0_i (p_q[0][U]), .pa1_i (p_q[0][W]),
        .pb0_i (p_q[1][U]), .pb1_i (p_q[1][W]),
        .pc0_i (p_q[2][U]), .pc1_i (p_q[2][W]),
        .lo0_i (lo_q[U]),  .lo1_i (lo_q[W]),
        .hi0_i (hi_q[U]),  .hi1_i (hi_q[W]),
        .sep_o (sep[i*3+j])
      );
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.overlaps = out_q;
endmodule

// ===== rtl/atov_checker.sv =====
// port-level checker for the box-triangle overlap test
`include "assert_macros.svh"
module atov_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input logic res_overlaps,
  input logic pready
);
  `CHK_PROP(a_pready, clk_i, rst_ni, pready, "pready low")
  `CHK_IMPL(a_hold, clk_i, rst_ni, res_valid && !res_ready, ##1 res_valid, "result dropped")
  `CHK_IMPL(a_stable, clk_i, rst_ni, res_valid && !res_ready, ##1 $stable(res_overlaps), "result changed")
endmodule

bind aabb_triangle_overlap atov_checker u_atov_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid   (res_o.valid),
  .res_ready   (res_o.ready),
  .res_overlaps(res_o.overlaps),
  .pready      (pready)
);

// ===== tb/sv/testbench.sv =====
// testbench for the box-triangle overlap test: directed table, random triangles, predictor
`timescale 1ns / 100ps
module testbench;
  import atov_pkg::*;

  typedef logic signed [15:0] coord_t;
  typedef struct {
    coord_t v[9];
    logic   chk;
    logic   ovl;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  atov_tri_if #(.CoordBits(16)) tri_if ();
  atov_res_if res_if ();

  aabb_triangle_overlap #(.CoordBits(16)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tri_i(tri_if.sink), .res_o(res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coord_t box_lo[3], box_hi[3];
  logic   overlap_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_res = 1'b0;
  tri_row_t rows[$];

  initial begin
    tri_if.valid = 1'b0;
    res_if.ready = 1'b0;
    {tri_if.a_x, tri_if.a_y, tri_if.a_z, tri_if.b_x, tri_if.b_y, tri_if.b_z,
     tri_if.c_x, tri_if.c_y, tri_if.c_z} = '0;
  end

  function automatic logic signed [63:0] dot(logic signed [63:0] p[3],
                                            logic signed [63:0] a[3]);
    return p[0] * a[0] + p[1] * a[1] + p[2] * a[2];
  endfunction

  function automatic logic predict_overlap(coord_t v[9]);
    logic signed [63:0] t[3][3], e[3][3], ax[3], p[3];
    logic signed [63:0] bmin, bmax, tmin, tmax, d, mn, mx;
    logic sep;
    sep = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) t[i][k] = v[i*3+k];
    for (int k = 0; k < 3; k++) begin
      mn = t[0][k];
      mx = t[0][k];
      for (int i = 1; i < 3; i++) begin
        if (t[i][k] < mn) mn = t[i][k];
        if (t[i][k] > mx) mx = t[i][k];
      end
      if (mx < box_lo[k] || mn > box_hi[k]) sep = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      e[0][k] = t[0][k] - t[1][k];
      e[1][k] = t[1][k] - t[2][k];
      e[2][k] = t[2][k] - t[0][k];
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (j == 0) begin ax[0] = 0; ax[1] = e[i][2]; ax[2] = -e[i][1]; end
        else if (j == 1) begin ax[0] = -e[i][2]; ax[1] = 0; ax[2] = e[i][0]; end
        else begin ax[0] = e[i][1]; ax[1] = -e[i][0]; ax[2] = 0; end
        if (!sep && (ax[0] != 0 || ax[1] != 0 || ax[2] != 0)) begin
          for (int c = 0; c < 8; c++) begin
            p[0] = c[2] ? box_hi[0] : box_lo[0];
            p[1] = c[1] ? box_hi[1] : box_lo[1];
            p[2] = c[0] ? box_hi[2] : box_lo[2];
            d = dot(p, ax);
            if (c == 0 || d < bmin) bmin = d;
            if (c == 0 || d > bmax) bmax = d;
          end
          for (int c = 0; c < 3; c++) begin
            d = dot(t[c], ax);
            if (c == 0 || d < tmin) tmin = d;
            if (c == 0 || d > tmax) tmax = d;
          end
          if (bmax < tmin || tmax < bmin) sep = 1'b1;
        end
      end
    return !sep;
  endfunction

  task automatic write_reg(reg_idx_e idx, coord_t val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PaddrW'(idx) << 2;
    pwdata <= {{16{val[15]}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx <= RegMinZ) box_lo[idx] = val;
    else box_hi[idx - RegMaxX] = val;
  endtask

  task automatic set_box(coord_t l[3], coord_t h[3]);
    tri_if.valid <= 1'b0;
    while (overlap_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_reg(RegMinX, l[0]); write_reg(RegMinY, l[1]); write_reg(RegMinZ, l[2]);
    write_reg(RegMaxX, h[0]); write_reg(RegMaxY, h[1]); write_reg(RegMaxZ, h[2]);
  endtask

  task automatic send_tri(coord_t v[9]);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      tri_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    tri_if.valid <= 1'b1;
    {tri_if.a_x, tri_if.a_y, tri_if.a_z, tri_if.b_x, tri_if.b_y, tri_if.b_z,
     tri_if.c_x, tri_if.c_y, tri_if.c_z} <=
      {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    do @(posedge clk_i); while (!tri_if.ready);
    @(negedge clk_i);
  endtask

  // push the prediction at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && tri_if.valid && tri_if.ready)
      overlap_q.push_back(predict_overlap('{tri_if.a_x, tri_if.a_y, tri_if.a_z,
        tri_if.b_x, tri_if.b_y, tri_if.b_z, tri_if.c_x, tri_if.c_y, tri_if.c_z}));
  end

  // queued before the push above in delta order would be racy; check reads result side only
  always @(posedge clk_i) begin
    logic exp_ovl;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (overlap_q.size() == 0) begin
        $display("%0t: unexpected result overlaps=%b", $time, res_if.overlaps);
        errors++;
      end else begin
        exp_ovl = overlap_q.pop_front();
        if (res_if.overlaps !== exp_ovl) begin
          $display("%0t: overlaps expected %b actual %b", $time, exp_ovl, res_if.overlaps);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_res) begin
        res_if.ready <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_res = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((tri_if.valid && tri_if.ready) || (res_if.valid && res_if.ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("aabb_triangle_overlap verification failed");
      $finish;
    end
  end

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    coord_t v[9], l[3], h[3], t;
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset the box is the origin point
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1});
    rows.push_back('{'{256, 256, 256, 512, 256, 256, 256, 512, 256}, 1, 0});
    rows.push_back('{'{-256, 0, 0, 256, 0, 0, 0, 256, 0}, 1, 1});
    rows.push_back('{'{-256, -256, 0, 256, -256, 0, 0, 256, 0}, 0, 0});
    foreach (rows[i]) begin
      if (rows[i].chk && predict_overlap(rows[i].v) !== rows[i].ovl) begin
        $display("%0t: table row %0d expected %b actual %b", $time, i, rows[i].ovl,
                 predict_overlap(rows[i].v));
        errors++;
      end
      send_tri(rows[i].v);
    end
    rows.delete();

    // widest box, extreme vertices and degenerate shapes
    set_box('{-32768, -32768, -32768}, '{32767, 32767, 32767});
    rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0}, 1, 1});
    rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1, 1});
    rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0}, 1, 1});
    rows.push_back('{'{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767}, 0, 0});
    rows.push_back('{'{-1, -1, -1, 1, 1, 1, 0, 0, 0}, 0, 0});
    foreach (rows[i]) send_tri(rows[i].v);
    rows.delete();

    // unit box and an inverted box
    set_box('{0, 0, 0}, '{256, 256, 256});
    rows.push_back('{'{1024, 0, 0, 0, 1024, 0, 0, 0, 1024}, 0, 0});
    rows.push_back('{'{600, 0, 0, 0, 600, 0, 0, 0, 600}, 0, 0});
    rows.push_back('{'{-512, 128, 128, 512, 128, 128, 0, 512, 128}, 0, 0});
    rows.push_back('{'{300, 300, 300, 400, 400, 400, 500, 300, 400}, 1, 0});
    foreach (rows[i]) send_tri(rows[i].v);
    rows.delete();
    set_box('{256, 256, 256}, '{-256, -256, -256});
    for (int i = 0; i < 4; i++) begin
      foreach (v[k]) v[k] = rnd_coord(600);
      send_tri(v);
    end

    // random: phases of boxes; vertices clustered near the box
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 3; k++) begin
        l[k] = rnd_coord(ph == 5 ? 0 : 8000);
        h[k] = rnd_coord(ph == 5 ? 0 : 8000);
        if (ph != 5 && l[k] > h[k]) begin t = l[k]; l[k] = h[k]; h[k] = t; end
      end
      set_box(l, h);
      if (ph == 2) hold_res = 1'b1;
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 310; n++) begin
        for (int k = 0; k < 9; k++) begin
          case ($urandom_range(0, 9))
            0: v[k] = coord_t'($urandom);
            1: v[k] = (k % 3 == 0) ? l[0] : (k % 3 == 1) ? l[1] : l[2];
            default:
              v[k] = coord_t'(((k % 3 == 0) ? (int'(l[0]) + h[0]) / 2 :
                               (k % 3 == 1) ? (int'(l[1]) + h[1]) / 2 :
                               (int'(l[2]) + h[2]) / 2) + int'(rnd_coord(9000)));
          endcase
        end
        send_tri(v);
      end
    end
    tri_if.valid <= 1'b0;
    while (overlap_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) $display("aabb_triangle_overlap verification clean");
    else $display("aabb_triangle_overlap verification failed");
    $finish;
  end
endmodule
